// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the page-write segmenter.
// No dependencies; the macros expect i_clk and i_rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EPWS_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("invariant violated");
`define EPWS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication violated");
`define EPWS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define EPWS_ASSERT(label, expr)
`define EPWS_ASSERT_IMP(label, ante, cons)
`define EPWS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/epws_pkg.sv =====
// Package of the page-write segmenter: widths, codes, config struct, part tables.
// No dependencies.
package epws_pkg;

    localparam int ADDR_W     = 11;
    localparam int LEN_W      = 12;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int MAX_REQUEST_BYTES = 512;
    // Page size cap; page offsets are taken with a mask, so keep it a power of two.
    localparam int MAX_PAGE_BYTES    = 16;

    localparam logic [7:0] BASE_DEVICE = 8'hA0;
    localparam logic [7:0] READ_BIT    = 8'h01;
    localparam logic [7:0] PIN_FIELD   = 8'h0E;
    localparam logic [7:0] TICKS_IDLE  = 8'hFF;

    localparam logic [2:0] MODEL_UNSET  = 3'd5;
    localparam logic [2:0] MODEL_16K    = 3'd4;
    localparam logic [7:0] WCT_RESET    = 8'd15;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_SETUP = 3'd1;
    localparam logic [2:0] ST_ADDR_BAD  = 3'd2;
    localparam logic [2:0] ST_SIZE_BAD  = 3'd3;
    localparam logic [2:0] ST_BUSY      = 3'd4;

    localparam logic [1:0] REG_MODEL  = 2'd0;
    localparam logic [1:0] REG_PINS   = 2'd1;
    localparam logic [1:0] REG_WTICKS = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SEG
    } t_state;

    typedef struct packed {
        logic [2:0] memory_model;
        logic [2:0] chip_pins;
        logic [7:0] write_cycle_ticks;
    } t_cfg;

    localparam logic [4:0] PAGE_CAP = 5'(MAX_PAGE_BYTES);

    function automatic logic [4:0] page_bytes(input logic [2:0] model);
        logic [4:0] raw;
        begin
            case (model)
                3'd0, 3'd1: raw = 5'd8;
                3'd2, 3'd3, 3'd4: raw = 5'd16;
                default: raw = 5'd0;
            endcase
            return (raw > PAGE_CAP) ? PAGE_CAP : raw;
        end
    endfunction

    function automatic logic [7:0] part_pages(input logic [2:0] model);
        case (model)
            3'd0:    return 8'd16;
            3'd1:    return 8'd32;
            3'd2:    return 8'd32;
            3'd3:    return 8'd64;
            3'd4:    return 8'd128;
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] part_mask(input logic [2:0] model);
        case (model)
            3'd2:    return 8'h02;
            3'd3:    return 8'h06;
            3'd4:    return 8'h0E;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] cap_bytes(input logic [2:0] model);
        logic [12:0] prod;
        begin
            prod = 13'(part_pages(model)) * 13'(page_bytes(model));
            return prod[LEN_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/epws_req_if.sv =====
// Request channel: each item is a tick, a write request or a read request.
// Depends on epws_pkg.
interface epws_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [epws_pkg::ADDR_W-1:0]   start_address;
    logic [epws_pkg::LEN_W-1:0]    request_length;

    modport source (output valid, kind, start_address, request_length, input ready);
    modport sink   (input valid, kind, start_address, request_length, output ready);
endinterface

// ===== rtl/epws_res_if.sv =====
// Result channel: one item per segment, read descriptor or error.
// Depends on epws_pkg.
interface epws_res_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic [7:0]                    dev_byte;
    logic [7:0]                    word_address;
    logic [epws_pkg::LEN_W-1:0]    transfer_length;
    logic [epws_pkg::ADDR_W-1:0]   data_offset;
    logic                          last_segment;

    modport source (output valid, status, dev_byte, word_address, transfer_length,
                    data_offset, last_segment, input ready);
    modport sink   (input valid, status, dev_byte, word_address, transfer_length,
                    data_offset, last_segment, output ready);
endinterface

// ===== rtl/epws_apb_regs.sv =====
// APB-style configuration registers of the page-write segmenter.
// Depends on epws_pkg.
module epws_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [epws_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [epws_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [epws_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output epws_pkg::t_cfg                    o_cfg
);

    epws_pkg::t_cfg r_cfg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.memory_model      <= epws_pkg::MODEL_UNSET;
            r_cfg.chip_pins         <= 3'd0;
            r_cfg.write_cycle_ticks <= epws_pkg::WCT_RESET;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                epws_pkg::REG_MODEL:  r_cfg.memory_model      <= pwdata[2:0];
                epws_pkg::REG_PINS:   r_cfg.chip_pins         <= pwdata[2:0];
                epws_pkg::REG_WTICKS: r_cfg.write_cycle_ticks <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            epws_pkg::REG_MODEL:  prdata = {29'd0, r_cfg.memory_model};
            epws_pkg::REG_PINS:   prdata = {29'd0, r_cfg.chip_pins};
            epws_pkg::REG_WTICKS: prdata = {24'd0, r_cfg.write_cycle_ticks};
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/eeprom_page_write_segmenter_top.sv =====
// Top level of the EEPROM page-write segmenter: request/result channels, APB port.
// Depends on epws_pkg, epws_req_if, epws_res_if, epws_apb_regs, assert_macros.svh.
//
// A write request is split into page-aligned segments, each with device byte, word
// address, length and offset; a read request gives one descriptor; a failed check
// gives one error item. The block takes one request at a time: it accepts the request in
// the idle state, runs the setup, range, size and busy checks in the check state, then
// gives one result item per cycle while the consumer is ready. Tick items advance the
// write-cycle timer. The segment length comes from a single subtract-and-compare
// unit stepped once per segment by the sequencer.
`include "assert_macros.svh"

module eeprom_page_write_segmenter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    epws_req_if.sink                          i_req,
    epws_res_if.source                        o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [epws_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [epws_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [epws_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int AW = epws_pkg::ADDR_W;
    localparam int LW = epws_pkg::LEN_W;

    epws_pkg::t_cfg   cfg;
    epws_pkg::t_state r_state, n_state;

    logic [1:0]    r_kind, n_kind;
    logic [AW-1:0] r_addr, n_addr;
    logic [LW-1:0] r_rem,  n_rem;
    logic [AW-1:0] r_off,  n_off;
    logic [7:0]    r_ticks, n_ticks;

    logic          r_o_valid, n_o_valid;
    logic [2:0]    r_o_status, n_o_status;
    logic [7:0]    r_o_dev, n_o_dev;
    logic [7:0]    r_o_word, n_o_word;
    logic [LW-1:0] r_o_len, n_o_len;
    logic [AW-1:0] r_o_off, n_o_off;
    logic          r_o_last, n_o_last;

    // Part description
    logic [4:0]    page;
    logic [7:0]    mask;
    logic [LW-1:0] cap;
    logic [7:0]    base;
    logic [7:0]    dev_cur;
    logic          busy;
    logic          unset;
    logic          addr_bad;
    logic          len_big;
    logic          end_bad;

    // Segment unit
    logic [4:0]    pos;
    logic [4:0]    room;
    logic [LW-1:0] seg;

    epws_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign page  = epws_pkg::page_bytes(cfg.memory_model);
    assign mask  = epws_pkg::part_mask(cfg.memory_model);
    assign cap   = epws_pkg::cap_bytes(cfg.memory_model);
    assign base  = epws_pkg::BASE_DEVICE |
                   ({4'd0, cfg.chip_pins, 1'b0} & epws_pkg::PIN_FIELD & ~mask);
    assign busy  = r_ticks <= cfg.write_cycle_ticks;
    assign unset = cfg.memory_model > epws_pkg::MODEL_16K;

    assign dev_cur  = base | ({4'd0, r_addr[10:7]} & mask);
    assign addr_bad = {1'b0, r_addr} >= cap;
    assign len_big  = r_rem > LW'(epws_pkg::MAX_REQUEST_BYTES);
    assign end_bad  = (r_rem != '0) && ((13'(r_addr) + 13'(r_rem)) > 13'(cap));

    // Bytes left in the current page, clipped to what remains of the request
    assign pos  = r_addr[4:0] & (page - 5'd1);
    assign room = page - pos;
    assign seg  = (r_rem < LW'(room)) ? r_rem : LW'(room);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= epws_pkg::S_IDLE;
            r_ticks   <= epws_pkg::TICKS_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ticks   <= n_ticks;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_addr     <= n_addr;
        r_rem      <= n_rem;
        r_off      <= n_off;
        r_o_status <= n_o_status;
        r_o_dev    <= n_o_dev;
        r_o_word   <= n_o_word;
        r_o_len    <= n_o_len;
        r_o_off    <= n_o_off;
        r_o_last   <= n_o_last;
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_addr     = r_addr;
        n_rem      = r_rem;
        n_off      = r_off;
        n_ticks    = r_ticks;
        n_o_valid  = r_o_valid;
        n_o_status = r_o_status;
        n_o_dev    = r_o_dev;
        n_o_word   = r_o_word;
        n_o_len    = r_o_len;
        n_o_off    = r_o_off;
        n_o_last   = r_o_last;

        unique case (r_state)
            epws_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.kind) inside
                        epws_pkg::KIND_TICK: begin
                            if (r_ticks != epws_pkg::TICKS_IDLE) begin
                                n_ticks = r_ticks + 8'd1;
                            end
                        end
                        epws_pkg::KIND_WRITE, epws_pkg::KIND_READ: begin
                            n_kind  = i_req.kind;
                            n_addr  = i_req.start_address;
                            n_rem   = i_req.request_length;
                            n_off   = '0;
                            n_state = epws_pkg::S_CHECK;
                        end
                        default: ;
                    endcase
                end
            end

            epws_pkg::S_CHECK: begin
                n_o_valid  = 1'b1;
                n_o_status = epws_pkg::ST_OK;
                n_o_dev    = '0;
                n_o_word   = '0;
                n_o_len    = '0;
                n_o_off    = '0;
                n_o_last   = 1'b1;
                n_state    = epws_pkg::S_SEG;
                if (unset) begin
                    n_o_status = epws_pkg::ST_NOT_SETUP;
                end else if (addr_bad) begin
                    n_o_status = epws_pkg::ST_ADDR_BAD;
                end else if (len_big ||
                             (end_bad && (r_kind == epws_pkg::KIND_WRITE))) begin
                    n_o_status = epws_pkg::ST_SIZE_BAD;
                end else if (busy) begin
                    n_o_status = epws_pkg::ST_BUSY;
                end else if (r_kind == epws_pkg::KIND_READ) begin
                    n_o_dev  = dev_cur | epws_pkg::READ_BIT;
                    n_o_word = r_addr[7:0];
                    n_o_len  = r_rem;
                end else if (r_rem == '0) begin
                    n_o_dev  = dev_cur;
                    n_o_word = r_addr[7:0];
                end else begin
                    // First segment; restart the write-cycle timer
                    n_o_dev  = dev_cur;
                    n_o_word = r_addr[7:0];
                    n_o_len  = seg;
                    n_o_last = (seg == r_rem);
                    n_addr   = r_addr + AW'(seg);
                    n_rem    = r_rem - seg;
                    n_off    = r_off + AW'(seg);
                    n_ticks  = '0;
                end
            end

            epws_pkg::S_SEG: begin
                if (o_res.ready) begin
                    if (r_o_last) begin
                        n_o_valid = 1'b0;
                        n_state   = epws_pkg::S_IDLE;
                    end else begin
                        // Advance to the next page
                        n_o_dev  = dev_cur;
                        n_o_word = r_addr[7:0];
                        n_o_len  = seg;
                        n_o_off  = r_off;
                        n_o_last = (seg == r_rem);
                        n_addr   = r_addr + AW'(seg);
                        n_rem    = r_rem - seg;
                        n_off    = r_off + AW'(seg);
                    end
                end
            end

            default: n_state = epws_pkg::S_IDLE;
        endcase
    end

    assign i_req.ready           = (r_state == epws_pkg::S_IDLE);
    assign o_res.valid           = r_o_valid;
    assign o_res.status          = r_o_status;
    assign o_res.dev_byte        = r_o_dev;
    assign o_res.word_address    = r_o_word;
    assign o_res.transfer_length = r_o_len;
    assign o_res.data_offset     = r_o_off;
    assign o_res.last_segment    = r_o_last;

    `EPWS_ASSERT(a_no_accept_while_result, !(i_req.ready && o_res.valid))
    `EPWS_ASSERT_IMP(a_error_is_last, o_res.valid && (o_res.status != epws_pkg::ST_OK), o_res.last_segment)
    `EPWS_ASSERT_IMP(a_seg_fits_page, o_res.valid && (o_res.status == epws_pkg::ST_OK) && !o_res.dev_byte[0], o_res.transfer_length <= LW'(epws_pkg::MAX_PAGE_BYTES))
    `EPWS_ASSERT_NXT(a_next_seg_follows, o_res.valid && o_res.ready && !o_res.last_segment, o_res.valid)

endmodule
